@@ rtl/afc_pkg.sv @@
// Shared types and constants for the bounding-box frustum cull block.
package afc_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FINISH
	} st_t;

	typedef struct packed {
		logic issue;
		logic first;
	} mac_ctl_t;

	localparam int unsigned MTX_REGS  = 8;
	localparam int unsigned ADDR_W    = 6;
	localparam int unsigned ACC_W     = 66;
	localparam int unsigned DEN_W     = 64;
	localparam int unsigned QUO_W     = 33;
	localparam int unsigned MUL_CNT_W = 3;

	localparam logic [MUL_CNT_W-1:0] MUL_DONE  = 3'd6;
	localparam logic [MUL_CNT_W-1:0] MUL_TERMS = 3'd4;
	localparam logic [1:0]           COL_W     = 2'd3;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage

@@ rtl/afc_corner_if.sv @@
// Input channel carrying one box corner per request.
interface afc_corner_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] corner_x;
	logic signed [31:0] corner_y;
	logic signed [31:0] corner_z;
	logic               last_corner;

	modport source (output valid, corner_x, corner_y, corner_z, last_corner, input ready);
	modport sink   (input valid, corner_x, corner_y, corner_z, last_corner, output ready);
endinterface

@@ rtl/afc_result_if.sv @@
// Output channel carrying one cull verdict per request.
interface afc_result_if;
	logic valid;
	logic ready;
	logic in_frustum;

	modport source (output valid, in_frustum, input ready);
	modport sink   (input valid, in_frustum, output ready);
endinterface

@@ rtl/aabb_frustum_cull.sv @@
// Top level: sequencer, matrix store, clip extremes and channel handling.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------
//  corner   | in  | valid/ready       | corner_x/y/z (s32 fixed), last_corner
//  result   | out | valid/ready       | in_frustum
//  apb      | in  | psel/penable/pwr  | paddr[5:3] = matrix reg, pwdata 64 bit
//
// From accept to the next ready, a corner whose w is zero runs only the w column;
// otherwise it takes 16 products through the single shared multiplier (four per
// column, incl. matrix read and accumulate) plus three restoring divisions (33
// steps and a done step; only the done step when the quotient saturates early).
// corner.ready is high only while the sequencer is idle.
// The result sits in an output register; a last corner waits in its finish
// step only while an earlier verdict is still untaken.
// Reset clears the matrix (valid bits per register) and the extremes.
module aabb_frustum_cull #(
	parameter int unsigned COORD_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [afc_pkg::ADDR_W-1:0]   paddr,
	input  logic [63:0]                  pwdata,
	output logic [63:0]                  prdata,
	output logic                         pready,
	afc_corner_if.sink                   corner,
	afc_result_if.source                 result
);

	localparam int unsigned NUM_W = afc_pkg::DEN_W + COORD_FRAC_BITS;
	localparam logic signed [31:0] ONE = 32'sd1 <<< COORD_FRAC_BITS;
	localparam logic signed [31:0] NEG_ONE = -ONE;

	afc_pkg::st_t st_q, st_d;

	// matrix store
	logic                               cfg_we;
	logic [2:0]                         cfg_idx;
	logic [afc_pkg::MTX_REGS-1:0]       cfg_vld_q;
	logic [2:0]                         mtx_raddr;
	logic [63:0]                        mtx_rd;
	logic [63:0]                        apb_rd;
	logic                               mtx_vld_s1;
	logic                               apb_vld_s1;

	// corner capture and sequencing
	logic signed [31:0]                 cx_q, cy_q, cz_q;
	logic                               last_q;
	logic [afc_pkg::MUL_CNT_W-1:0]      cnt_q;
	logic [1:0]                         col_q;
	logic [afc_pkg::DEN_W-1:0]          den_q;

	// arithmetic
	afc_pkg::mac_ctl_t                  mac_ctl;
	logic signed [31:0]                 op_a, op_b;
	logic [1:0]                         term;
	logic signed [afc_pkg::ACC_W-1:0]   acc;
	logic                               acc_zero;
	logic [afc_pkg::DEN_W-1:0]          acc_mag;
	logic                               div_start;
	logic                               div_done;
	logic signed [31:0]                 quo;
	logic                               mul_end;

	// extremes and result
	logic signed [31:0]                 max_x_q, max_y_q, max_z_q;
	logic signed [31:0]                 min_x_q, min_y_q, min_z_q;
	logic                               res_valid_q;
	logic                               res_q;
	logic                               res_free;
	logic                               hit;

	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	afc_ram #(
		.WIDTH (64),
		.DEPTH (afc_pkg::MTX_REGS)
	) u_mtx (
		.clk    (clk),
		.we     (cfg_we),
		.waddr  (cfg_idx),
		.wdata  (pwdata),
		.raddr0 (mtx_raddr),
		.rdata0 (mtx_rd),
		.raddr1 (cfg_idx),
		.rdata1 (apb_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_vld_q <= '0;
		end else if (cfg_we) begin
			cfg_vld_q[cfg_idx] <= 1'b1;
		end
	end

	// valid bits follow the registered reads; unwritten entries read as zero
	always_ff @(posedge clk) begin
		mtx_vld_s1 <= cfg_vld_q[mtx_raddr];
		apb_vld_s1 <= cfg_vld_q[cfg_idx];
	end

	assign prdata = apb_vld_s1 ? apb_rd : 64'd0;

	// matrix entry M[term][col]: register {term, col[1]}, word col[0]
	assign mtx_raddr = {cnt_q[1:0], col_q[1]};
	assign term      = 2'(cnt_q - 1'b1);

	always_comb begin
		if (!mtx_vld_s1) begin
			op_b = '0;
		end else if (col_q[0]) begin
			op_b = $signed(mtx_rd[63:32]);
		end else begin
			op_b = $signed(mtx_rd[31:0]);
		end
		case (term)
			2'd0:    op_a = cx_q;
			2'd1:    op_a = cy_q;
			2'd2:    op_a = cz_q;
			default: op_a = ONE;
		endcase
	end

	afc_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	assign acc_zero = acc == '0;
	assign acc_mag  = acc[afc_pkg::ACC_W-1] ? (~acc[afc_pkg::DEN_W-1:0] + 1'b1)
	                                        : acc[afc_pkg::DEN_W-1:0];

	afc_div #(
		.NUM_W (NUM_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({acc_mag, {COORD_FRAC_BITS{1'b0}}}),
		.neg    (acc[afc_pkg::ACC_W-1]),
		.den    (den_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign mul_end  = st_q == afc_pkg::ST_MUL && cnt_q == afc_pkg::MUL_DONE;
	assign res_free = !res_valid_q || result.ready;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			afc_pkg::ST_IDLE: begin
				if (corner.valid) st_d = afc_pkg::ST_MUL;
			end
			afc_pkg::ST_MUL: begin
				if (cnt_q == afc_pkg::MUL_DONE) begin
					if (col_q == afc_pkg::COL_W) begin
						// zero w: corner is skipped
						if (acc_zero) st_d = afc_pkg::ST_FINISH;
					end else begin
						st_d = afc_pkg::ST_DIV;
					end
				end
			end
			afc_pkg::ST_DIV: begin
				if (div_done) begin
					st_d = (col_q == 2'd2) ? afc_pkg::ST_FINISH : afc_pkg::ST_MUL;
				end
			end
			afc_pkg::ST_FINISH: begin
				if (!last_q || res_free) st_d = afc_pkg::ST_IDLE;
			end
			default: st_d = afc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		corner.ready  = 1'b0;
		mac_ctl.issue = 1'b0;
		mac_ctl.first = 1'b0;
		div_start     = 1'b0;
		case (st_q)
			afc_pkg::ST_IDLE: begin
				corner.ready = 1'b1;
			end
			afc_pkg::ST_MUL: begin
				mac_ctl.issue = cnt_q != '0 && cnt_q <= afc_pkg::MUL_TERMS;
				mac_ctl.first = cnt_q == 3'd1;
				div_start     = mul_end && col_q != afc_pkg::COL_W;
			end
			default: begin
			end
		endcase
	end

	assign hit = max_x_q > NEG_ONE && max_y_q > NEG_ONE && max_z_q > 32'sd0 &&
	             min_x_q < ONE && min_y_q < ONE && min_z_q < ONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= afc_pkg::ST_IDLE;
			cnt_q       <= '0;
			col_q       <= '0;
			res_valid_q <= 1'b0;
			max_x_q     <= afc_pkg::S32_MIN;
			max_y_q     <= afc_pkg::S32_MIN;
			max_z_q     <= afc_pkg::S32_MIN;
			min_x_q     <= afc_pkg::S32_MAX;
			min_y_q     <= afc_pkg::S32_MAX;
			min_z_q     <= afc_pkg::S32_MAX;
		end else begin
			st_q <= st_d;
			// a new verdict may load in the cycle the old one is taken
			if (st_q == afc_pkg::ST_FINISH && last_q && res_free) begin
				res_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (st_q)
				afc_pkg::ST_IDLE: begin
					cnt_q <= '0;
					col_q <= afc_pkg::COL_W;  // w column first
				end
				afc_pkg::ST_MUL: begin
					if (mul_end) begin
						cnt_q <= '0;
						if (col_q == afc_pkg::COL_W) col_q <= 2'd0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				afc_pkg::ST_DIV: begin
					if (div_done) begin
						col_q <= col_q + 1'b1;
						case (col_q)
							2'd0: begin
								if (quo > max_x_q) max_x_q <= quo;
								if (quo < min_x_q) min_x_q <= quo;
							end
							2'd1: begin
								if (quo > max_y_q) max_y_q <= quo;
								if (quo < min_y_q) min_y_q <= quo;
							end
							default: begin
								if (quo > max_z_q) max_z_q <= quo;
								if (quo < min_z_q) min_z_q <= quo;
							end
						endcase
					end
				end
				afc_pkg::ST_FINISH: begin
					if (last_q && res_free) begin
						max_x_q     <= afc_pkg::S32_MIN;
						max_y_q     <= afc_pkg::S32_MIN;
						max_z_q     <= afc_pkg::S32_MIN;
						min_x_q     <= afc_pkg::S32_MAX;
						min_y_q     <= afc_pkg::S32_MAX;
						min_z_q     <= afc_pkg::S32_MAX;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (corner.valid && corner.ready) begin
			cx_q   <= corner.corner_x;
			cy_q   <= corner.corner_y;
			cz_q   <= corner.corner_z;
			last_q <= corner.last_corner;
		end
		if (mul_end && col_q == afc_pkg::COL_W) den_q <= acc_mag;
		if (st_q == afc_pkg::ST_FINISH && last_q && res_free) res_q <= hit;
	end

	assign result.valid      = res_valid_q;
	assign result.in_frustum = res_q;

endmodule

@@ rtl/afc_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module afc_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	output logic [WIDTH-1:0]         rdata0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata1
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end

endmodule

@@ rtl/afc_mac.sv @@
// Shared 32x32 signed multiplier with a registered product and wide accumulator.
module afc_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  afc_pkg::mac_ctl_t                ctl,
	input  logic signed [31:0]               op_a,
	input  logic signed [31:0]               op_b,
	output logic signed [afc_pkg::ACC_W-1:0] acc
);

	logic signed [63:0]               prod_s1;
	logic                             valid_s1;
	logic                             first_s1;
	logic signed [afc_pkg::ACC_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			first_s1 <= ctl.first;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			prod_s1 <= op_a * op_b;
		end
		if (valid_s1) begin
			if (first_s1) begin
				acc_q <= (afc_pkg::ACC_W)'(prod_s1);
			end else begin
				acc_q <= acc_q + (afc_pkg::ACC_W)'(prod_s1);
			end
		end
	end

	assign acc = acc_q;

endmodule

@@ rtl/afc_div.sv @@
// Restoring divider, one quotient bit per cycle, saturating signed 32-bit result.
module afc_div #(
	parameter int unsigned NUM_W = 80
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [NUM_W-1:0]                 num,
	input  logic                             neg,
	input  logic [afc_pkg::DEN_W-1:0]        den,
	output logic                             done,
	output logic signed [31:0]               quo
);

	localparam int unsigned QW   = afc_pkg::QUO_W;
	localparam int unsigned CW   = $clog2(QW + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CW-1:0]             cnt_q;
	logic [afc_pkg::DEN_W-1:0] rem_q;
	logic [QW-1:0]             lo_q;
	logic [QW-1:0]             q_q;
	logic                      sat_q;
	logic                      neg_q;

	logic [afc_pkg::DEN_W-1:0] num_hi;
	logic [afc_pkg::DEN_W:0]   trial;
	logic                      fits;

	assign num_hi = (afc_pkg::DEN_W)'(num[NUM_W-1:QW]);
	assign trial  = {rem_q, lo_q[QW-1]};
	assign fits   = trial >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				// quotient of 2^33 or more always saturates
				if (num_hi >= den) begin
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
					busy_q <= 1'b1;
					cnt_q  <= CW'(QW);
				end
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= num_hi >= den;
			neg_q <= neg;
			rem_q <= num_hi;
			lo_q  <= num[QW-1:0];
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? trial[afc_pkg::DEN_W-1:0] - den : trial[afc_pkg::DEN_W-1:0];
			lo_q  <= {lo_q[QW-2:0], 1'b0};
			q_q   <= {q_q[QW-2:0], fits};
		end
	end

	always_comb begin
		if (neg_q) begin
			if (sat_q || q_q > QW'(33'h0_8000_0000)) begin
				quo = afc_pkg::S32_MIN;
			end else begin
				quo = -$signed(q_q[31:0]);
			end
		end else begin
			if (sat_q || q_q > QW'(33'h0_7FFF_FFFF)) begin
				quo = afc_pkg::S32_MAX;
			end else begin
				quo = $signed(q_q[31:0]);
			end
		end
	end

	assign done = done_q;

endmodule
